>>> rtl/sobel_pkg.sv
// Shared types and constants for the Sobel edge magnitude stream block.
// Holds the sequencer state type, register indexes and arithmetic constants.
// No dependencies.
package sobel_pkg;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_READ = 8'b0000_0010,
    S_GRAD = 8'b0000_0100,
    S_SQR  = 8'b0000_1000,
    S_SUM  = 8'b0001_0000,
    S_ROOT = 8'b0010_0000,
    S_INT  = 8'b0100_0000,
    S_BRD  = 8'b1000_0000
  } seq_state_t;

  localparam logic       REG_FRAME_WIDTH  = 1'b0;
  localparam logic       REG_FRAME_HEIGHT = 1'b1;

  localparam logic [11:0] WIDTH_RESET  = 12'd640;
  localparam logic [11:0] HEIGHT_RESET = 12'd480;
  localparam logic [11:0] SIZE_MIN     = 12'd3;

  // floor(s / 3) equals (s * 683) >> 11 for every s up to 765.
  localparam logic [10:0] GRAY_RECIP = 11'd683;
  localparam int          GRAY_SHIFT = 11;

  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0]  MAG_MAX      = 8'hFF;

endpackage

>>> rtl/sobel_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Used for the gray line buffers of the Sobel block; no dependencies.
module sobel_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/sobel_edge_magnitude_stream.sv
// Sobel edge magnitude over a raster-order ARGB pixel stream.
// Uses sobel_pkg for types and constants and sobel_ram for the line buffers.
//
// Pixels enter on the s_axis channel, one ARGB pixel per beat, in raster order.
// Results leave on the m_axis channel; each beat carries column, row and the
// output pixel, with tlast on the last beat caused by an input pixel and tuser
// on the bottom-right pixel of the frame. A pixel causes zero, one or two beats.
// Frame size is set through the APB port at byte addresses 0 (width) and 4
// (height); sizes are clamped to 3 up to the maximum. Write them only while idle.
// Each pixel walks a sequencer: line-buffer read, gray conversion, gradient,
// squaring, sum, eight square-root steps, then emission. A new pixel is
// accepted only in the idle state, after the previous one has left the
// sequencer; its interior beat, if any, is emitted before its border beat.
// The output beat sits in a register, so the next pixel is taken while a
// result still waits; a stalled receiver holds the sequencer only at emission.
// Synchronous reset restores the default 640x480 size, clears the window and
// the position counters. The line buffers need no clearing pass because stale
// contents reach only the first two rows, which emit no interior beat.
module sobel_edge_magnitude_stream
  import sobel_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // pixel_argb
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // out_column[10:0], out_row[21:11], out_pixel[53:22]
  output logic        m_axis_tlast,   // last_of_run
  output logic        m_axis_tuser    // end_of_frame
);

  localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int LWW = (CW + 1 > 12) ? CW + 1 : 12;
  localparam int LWH = (RW + 1 > 12) ? RW + 1 : 12;

  logic [11:0] frame_width;
  logic [11:0] frame_height;

  seq_state_t state;
  seq_state_t state_next;

  logic [CW-1:0] col_cnt;
  logic [RW-1:0] row_cnt;

  logic [31:0]   px_q;
  logic [CW-1:0] c_q;
  logic [RW-1:0] r_q;
  logic          is_bdr_q;
  logic          has_int_q;
  logic          eof_q;

  logic [7:0]  gray_q;
  logic [7:0]  n0_q;
  logic [7:0]  n1_q;
  logic [7:0]  taps [6];
  logic [9:0]  gxa_q;
  logic [9:0]  gya_q;
  logic [19:0] gx2_q;
  logic [19:0] gy2_q;
  logic [15:0] v_q;
  logic        sat_q;
  logic [7:0]  root_q;
  logic [7:0]  bit_q;

  // Configuration registers
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_FRAME_HEIGHT) ? 32'(frame_height) : 32'(frame_width);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_FRAME_WIDTH) begin
        frame_width <= pwdata[11:0];
      end else begin
        frame_height <= pwdata[11:0];
      end
    end
  end

  // Effective frame size and clamped position
  logic [LWW-1:0] fw_ext, w_eff, w_last;
  logic [LWH-1:0] fh_ext, h_eff, h_last;
  logic [CW-1:0]  c_cur;
  logic [RW-1:0]  r_cur;
  logic           c_at_end, r_at_end;

  always_comb begin
    fw_ext = LWW'(frame_width);
    fh_ext = LWH'(frame_height);
    if (fw_ext < LWW'(SIZE_MIN)) begin
      w_eff = LWW'(SIZE_MIN);
    end else if (fw_ext > LWW'(MAX_WIDTH)) begin
      w_eff = LWW'(MAX_WIDTH);
    end else begin
      w_eff = fw_ext;
    end
    if (fh_ext < LWH'(SIZE_MIN)) begin
      h_eff = LWH'(SIZE_MIN);
    end else if (fh_ext > LWH'(MAX_HEIGHT)) begin
      h_eff = LWH'(MAX_HEIGHT);
    end else begin
      h_eff = fh_ext;
    end
    w_last = w_eff - LWW'(1);
    h_last = h_eff - LWH'(1);
    c_cur  = (LWW'(col_cnt) > w_last) ? w_last[CW-1:0] : col_cnt;
    r_cur  = (LWH'(row_cnt) > h_last) ? h_last[RW-1:0] : row_cnt;
    c_at_end = (LWW'(c_cur) == w_last);
    r_at_end = (LWH'(r_cur) == h_last);
  end

  logic in_acc;
  assign s_axis_tready = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Line buffers: upper byte is the row two above, lower byte the row above.
  logic        ram_we;
  logic [15:0] ram_rdata;

  sobel_ram #(
    .WIDTH (16),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (c_q),
    .wdata ({n1_q, gray_q}),
    .raddr (c_cur),
    .rdata (ram_rdata)
  );

  assign ram_we = (state == S_GRAD);

  // Datapath arithmetic
  logic [9:0]  rgb_sum;
  logic [20:0] gray_prod;
  logic [9:0]  lsum, rsum, tsum, bsum;
  logic [10:0] gx, gy;
  logic [20:0] sq_sum;
  logic [7:0]  root_try;
  logic [15:0] root_sq;
  logic [7:0]  mag;

  always_comb begin
    rgb_sum   = 10'(px_q[23:16]) + 10'(px_q[15:8]) + 10'(px_q[7:0]);
    gray_prod = 21'(rgb_sum) * 21'(GRAY_RECIP);
    lsum = 10'(taps[0]) + {1'b0, taps[1], 1'b0} + 10'(taps[2]);
    rsum = 10'(n0_q) + {1'b0, n1_q, 1'b0} + 10'(gray_q);
    tsum = 10'(taps[0]) + {1'b0, taps[3], 1'b0} + 10'(n0_q);
    bsum = 10'(taps[2]) + {1'b0, taps[5], 1'b0} + 10'(gray_q);
    gx = {1'b0, lsum} - {1'b0, rsum};
    gy = {1'b0, tsum} - {1'b0, bsum};
    sq_sum   = 21'(gx2_q) + 21'(gy2_q);
    root_try = root_q | bit_q;
    root_sq  = 16'(root_try) * 16'(root_try);
    mag      = sat_q ? MAG_MAX : root_q;
  end

  // Output register
  logic out_free;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_acc) state_next = S_READ;
      S_READ: state_next = S_GRAD;
      S_GRAD: state_next = S_SQR;
      S_SQR:  state_next = S_SUM;
      S_SUM:  state_next = S_ROOT;
      S_ROOT: if (bit_q[0]) state_next = S_INT;
      S_INT: begin
        if (!has_int_q || out_free) begin
          state_next = is_bdr_q ? S_BRD : S_IDLE;
        end
      end
      S_BRD: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      col_cnt <= '0;
      row_cnt <= '0;
      for (int i = 0; i < 6; i++) begin
        taps[i] <= '0;
      end
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        if (c_at_end) begin
          col_cnt <= '0;
          row_cnt <= r_at_end ? '0 : r_cur + RW'(1);
        end else begin
          col_cnt <= c_cur + CW'(1);
          row_cnt <= r_cur;
        end
      end
      if (state == S_GRAD) begin
        taps[0] <= taps[3];
        taps[1] <= taps[4];
        taps[2] <= taps[5];
        taps[3] <= n0_q;
        taps[4] <= n1_q;
        taps[5] <= gray_q;
      end
      if ((state == S_INT && has_int_q && out_free) || (state == S_BRD && out_free)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      px_q      <= s_axis_tdata;
      c_q       <= c_cur;
      r_q       <= r_cur;
      is_bdr_q  <= (c_cur == '0) || c_at_end || (r_cur == '0) || r_at_end;
      has_int_q <= (LWW'(c_cur) >= LWW'(2)) && (LWH'(r_cur) >= LWH'(2));
      eof_q     <= c_at_end && r_at_end;
    end
    if (state == S_READ) begin
      gray_q <= is_bdr_q ? 8'd0 : gray_prod[GRAY_SHIFT+7:GRAY_SHIFT];
      n0_q   <= ram_rdata[15:8];
      n1_q   <= ram_rdata[7:0];
    end
    if (state == S_GRAD) begin
      gxa_q <= gx[10] ? 10'(-gx) : gx[9:0];
      gya_q <= gy[10] ? 10'(-gy) : gy[9:0];
    end
    if (state == S_SQR) begin
      gx2_q <= 20'(gxa_q) * 20'(gxa_q);
      gy2_q <= 20'(gya_q) * 20'(gya_q);
    end
    if (state == S_SUM) begin
      v_q    <= sq_sum[15:0];
      sat_q  <= |sq_sum[20:16];
      root_q <= '0;
      bit_q  <= 8'h80;
    end
    if (state == S_ROOT) begin
      if (root_sq <= v_q) begin
        root_q <= root_try;
      end
      bit_q <= bit_q >> 1;
    end
    if (state == S_INT && has_int_q && out_free) begin
      m_axis_tdata <= {2'b00, ALPHA_OPAQUE, mag, mag, mag,
                       11'(r_q - RW'(1)), 11'(c_q - CW'(1))};
      m_axis_tlast <= !is_bdr_q;
      m_axis_tuser <= 1'b0;
    end else if (state == S_BRD && out_free) begin
      m_axis_tdata <= {2'b00, 32'd0, 11'(r_q), 11'(c_q)};
      m_axis_tlast <= 1'b1;
      m_axis_tuser <= eof_q;
    end
  end

endmodule

>>> dv/sobel_edge_magnitude_stream_test.sv
// Self-checking testbench for sobel_edge_magnitude_stream.
// Predicts every result beat of the Sobel edge stream across many frame sizes and
// handshake pressure phases. Depends on sobel_pkg and the block's RTL only.
module sobel_edge_magnitude_stream_test;
  import sobel_pkg::*;

  localparam int LINE_MAX = 2048;
  localparam int ROWS_MAX = 2048;
  localparam int DRAIN_CYCLES = 30;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_PIXELS = 340;
  localparam int REPORT_MAX = 10;

  typedef enum int {
    PIX_RANDOM,
    PIX_LOW_CONTRAST,
    PIX_BINARY
  } pixel_style_t;

  typedef struct packed {
    logic [10:0] column;
    logic [10:0] row;
    logic [31:0] pixel;
    logic        last;
    logic        frame_end;
  } edge_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  sobel_edge_magnitude_stream DUT (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  logic [31:0] pixel_queue[$];
  edge_beat_t  expected_beats[$];
  logic        pixel_taken = 1'b0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          mismatch_count = 0;
  int          beats_checked = 0;
  int          frames_ended = 0;
  int          pixels_fed = 0;
  int          sizes_used = 0;
  int          cycle_count = 0;
  edge_beat_t  seen_beat;
  edge_beat_t  want_beat;

  // Predictor state.
  logic [11:0] width_reg = WIDTH_RESET;
  logic [11:0] height_reg = HEIGHT_RESET;
  int          gray_above[LINE_MAX];
  int          gray_two_above[LINE_MAX];
  int          taps[6];
  int          col_pos = 0;
  int          row_pos = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d beats outstanding.", cycle_count,
               expected_beats.size());
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int clamp_size(input logic [11:0] v, input int hi);
    if (v < SIZE_MIN) return int'(SIZE_MIN);
    if (v > hi) return hi;
    return int'(v);
  endfunction

  function automatic int edge_root(input int v);
    int root;
    int trial;
    if (v >= 65536) return MAG_MAX;
    root = 0;
    for (int b = 7; b >= 0; b--) begin
      trial = root | (1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  task automatic predict_pixel(input logic [31:0] px);
    int w;
    int h;
    int c;
    int r;
    int gray;
    int n0;
    int n1;
    int gx;
    int gy;
    int count;
    logic [7:0] mag;
    logic border;
    edge_beat_t beats[2];
    w = clamp_size(width_reg, LINE_MAX);
    h = clamp_size(height_reg, ROWS_MAX);
    if (col_pos > w - 1) col_pos = w - 1;
    if (row_pos > h - 1) row_pos = h - 1;
    c = col_pos;
    r = row_pos;
    border = (c == 0) || (c == w - 1) || (r == 0) || (r == h - 1);
    gray = (int'(px[23:16]) + int'(px[15:8]) + int'(px[7:0])) / 3;
    if (border) gray = 0;
    n0 = gray_two_above[c];
    n1 = gray_above[c];
    count = 0;
    if (r >= 2 && c >= 2) begin
      gx = (taps[0] + 2 * taps[1] + taps[2]) - (n0 + 2 * n1 + gray);
      gy = (taps[0] + 2 * taps[3] + n0) - (taps[2] + 2 * taps[5] + gray);
      mag = 8'(edge_root(gx * gx + gy * gy));
      beats[count].column = 11'(c - 1);
      beats[count].row = 11'(r - 1);
      beats[count].pixel = {ALPHA_OPAQUE, mag, mag, mag};
      beats[count].last = 1'b0;
      beats[count].frame_end = 1'b0;
      count++;
    end
    if (border) begin
      beats[count].column = 11'(c);
      beats[count].row = 11'(r);
      beats[count].pixel = '0;
      beats[count].last = 1'b0;
      beats[count].frame_end = (r == h - 1) && (c == w - 1);
      count++;
    end
    if (count > 0) beats[count - 1].last = 1'b1;
    for (int i = 0; i < count; i++) expected_beats.push_back(beats[i]);
    taps[0] = taps[3];
    taps[1] = taps[4];
    taps[2] = taps[5];
    taps[3] = n0;
    taps[4] = n1;
    taps[5] = gray;
    gray_two_above[c] = n1;
    gray_above[c] = gray;
    if (c >= w - 1) begin
      col_pos = 0;
      row_pos = (r >= h - 1) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || pixel_taken) begin
      if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tdata <= pixel_queue.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    pixel_taken <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen_beat.column = m_axis_tdata[10:0];
        seen_beat.row = m_axis_tdata[21:11];
        seen_beat.pixel = m_axis_tdata[53:22];
        seen_beat.last = m_axis_tlast;
        seen_beat.frame_end = m_axis_tuser;
        beats_checked++;
        if (seen_beat.frame_end) frames_ended++;
        if (expected_beats.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("Unexpected beat: col %0d row %0d pixel %h last %b eof %b",
                     seen_beat.column, seen_beat.row, seen_beat.pixel, seen_beat.last,
                     seen_beat.frame_end);
        end else begin
          want_beat = expected_beats.pop_front();
          if (seen_beat !== want_beat) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
              $display("Beat %0d: expected col %0d row %0d pixel %h last %b eof %b,",
                       beats_checked, want_beat.column, want_beat.row, want_beat.pixel,
                       want_beat.last, want_beat.frame_end,
                       " got col %0d row %0d pixel %h last %b eof %b",
                       seen_beat.column, seen_beat.row, seen_beat.pixel,
                       seen_beat.last, seen_beat.frame_end);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_pixel(s_axis_tdata);
    end
  end

  task automatic wait_drained();
    while (pixel_queue.size() > 0 || s_axis_tvalid || expected_beats.size() > 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_frame_size(input int w, input int h);
    logic [31:0] w_word;
    logic [31:0] h_word;
    wait_drained();
    w_word = {20'($urandom_range(1048575)), w[11:0]};
    h_word = {20'($urandom_range(1048575)), h[11:0]};
    apb_write({REG_FRAME_WIDTH, 2'b00}, w_word);
    apb_write({REG_FRAME_HEIGHT, 2'b00}, h_word);
    width_reg = w_word[11:0];
    height_reg = h_word[11:0];
    sizes_used++;
  endtask

  function automatic int pixels_to_frame_end();
    int w;
    int h;
    int c;
    int r;
    w = clamp_size(width_reg, LINE_MAX);
    h = clamp_size(height_reg, ROWS_MAX);
    c = (col_pos > w - 1) ? w - 1 : col_pos;
    r = (row_pos > h - 1) ? h - 1 : row_pos;
    return (h - 1 - r) * w + (w - c);
  endfunction

  function automatic logic [31:0] make_pixel(input pixel_style_t style, input int base);
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    alpha = 8'($urandom_range(255));
    case (style)
      PIX_LOW_CONTRAST: begin
        red = 8'(base + $urandom_range(15));
        green = 8'(base + $urandom_range(15));
        blue = 8'(base + $urandom_range(15));
        return {alpha, red, green, blue};
      end
      PIX_BINARY: begin
        return {alpha, ($urandom_range(1) != 0) ? 24'hFFFFFF : 24'h000000};
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  task automatic feed_pixels(input int n, input pixel_style_t style);
    int base;
    base = $urandom_range(240);
    for (int i = 0; i < n; i++) pixel_queue.push_back(make_pixel(style, base));
    pixels_fed += n;
  endtask

  task automatic run_random_frames(input int budget);
    int w;
    int h;
    int n;
    int done;
    done = 0;
    while (done < budget) begin
      w = $urandom_range(3, 12);
      h = $urandom_range(3, 9);
      if ($urandom_range(7) == 0) w = $urandom_range(2);
      if ($urandom_range(7) == 0) h = $urandom_range(2);
      set_frame_size(w, h);
      n = pixels_to_frame_end();
      if ($urandom_range(3) == 0) n = 2 * n;
      feed_pixels(n, pixel_style_t'($urandom_range(2)));
      done += n;
    end
  endtask

  logic [31:0] corner_pixels[25] = '{
    32'h00000000, 32'hFFFFFFFF, 32'h00FFFFFF, 32'hFF000000, 32'h80808080,
    32'h7F7F7F7F, 32'h00FF0000, 32'h0000FF00, 32'h000000FF,
    32'h00000000, 32'hFFFFFFFF, 32'h00FFFFFF, 32'hFF000000,
    32'h00000000, 32'h00FFFFFF, 32'h00000000, 32'hFFFFFFFF,
    32'h12345678, 32'h00FF0000, 32'h00FFFFFF, 32'h0000FF00,
    32'h000000FF, 32'h80808080, 32'h7F7F7F7F, 32'hFFFFFFFF
  };

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Undersized registers clamp to the smallest 3x3 frame.
    set_frame_size(0, 1);
    for (int i = 0; i < 9; i++) pixel_queue.push_back(corner_pixels[i]);
    set_frame_size(4, 4);
    for (int i = 9; i < 25; i++) pixel_queue.push_back(corner_pixels[i]);
    pixels_fed += 25;

    // Height shrinks below the current row in mid-frame.
    set_frame_size(3, ROWS_MAX);
    feed_pixels(60, PIX_RANDOM);
    set_frame_size(3, 6);
    feed_pixels(pixels_to_frame_end(), PIX_LOW_CONTRAST);

    // Width shrinks past the current column in mid-frame.
    set_frame_size(12, 10);
    feed_pixels(31, PIX_BINARY);
    set_frame_size(5, 10);
    feed_pixels(pixels_to_frame_end(), PIX_RANDOM);

    // Oversized width starts a wide first row, which is then cut short.
    set_frame_size(4095, 0);
    feed_pixels(40, PIX_RANDOM);
    set_frame_size(6, 0);
    feed_pixels(pixels_to_frame_end(), PIX_RANDOM);

    run_random_frames(PHASE_PIXELS);

    wait_drained();
    send_idle_pct = 72;
    run_random_frames(PHASE_PIXELS);

    wait_drained();
    send_idle_pct = 0;
    recv_stall_pct = 72;
    run_random_frames(PHASE_PIXELS);

    wait_drained();
    send_idle_pct = 33;
    recv_stall_pct = 33;
    run_random_frames(PHASE_PIXELS);

    wait_drained();
    $display("Sent %0d pixels over %0d size settings; ", pixels_fed, sizes_used,
             "checked %0d result beats, %0d frame ends.", beats_checked, frames_ended);
    $display("Idle phases: none, sender 72%%, receiver 72%%, both 33%%; %0d mismatches.",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
